FILE: src/dmac4_pkg.sv
// package: item kinds, port decode constants and controller-to-datapath command type
`timescale 1ns / 1ps

package dmac4_pkg;

    // item kinds carried in the input tuser
    typedef enum logic [1:0] {
        CMD_PORT_RD = 2'd0,
        CMD_PORT_WR = 2'd1,
        CMD_XFER_RD = 2'd2,
        CMD_XFER_WR = 2'd3
    } t_cmd;

    // controller register nibbles (port below 0x80)
    localparam logic [3:0] NIB_STATUS  = 4'h8;
    localparam logic [3:0] NIB_MODE    = 4'hB;
    localparam logic [3:0] NIB_CLR_FF  = 4'hC;
    localparam logic [3:0] NIB_MRESET  = 4'hD;

    // page register nibbles (port 0x80 and above)
    localparam logic [3:0] NIB_PAGE_CH2 = 4'h1;
    localparam logic [3:0] NIB_PAGE_CH3 = 4'h2;
    localparam logic [3:0] NIB_PAGE_CH1 = 4'h3;
    localparam logic [3:0] NIB_PAGE_CH0 = 4'h7;

    localparam logic [7:0] STATUS_BYTE   = 8'h0F;
    localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;

    // mode byte bit positions
    localparam int MODE_AUTOINIT_BIT  = 4;
    localparam int MODE_DECREMENT_BIT = 5;

    localparam int NUM_CH = 4;

    // page port nibble to channel, bit 2 marks an assigned port
    function automatic logic [2:0] page_channel(input logic [3:0] nib);
        logic [2:0] r;
        unique case (nib)
            NIB_PAGE_CH2: r = {1'b1, 2'd2};
            NIB_PAGE_CH3: r = {1'b1, 2'd3};
            NIB_PAGE_CH1: r = {1'b1, 2'd1};
            NIB_PAGE_CH0: r = {1'b1, 2'd0};
            default:      r = 3'b000;
        endcase
        return r;
    endfunction

    // command from the controller to the datapath
    typedef struct packed {
        logic load;
        t_cmd op;
    } t_dp_cmd;

endpackage

FILE: src/dmac4_ctrl.sv
// controller: handshake state machine and item kind decode
`timescale 1ns / 1ps

module dmac4_ctrl
    import dmac4_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_kind,
    input  logic       i_out_ready,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    typedef enum logic {
        ST_EMPTY,
        ST_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // a new item may enter while the held result leaves
    assign o_in_ready  = (r_state == ST_EMPTY) || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == ST_HOLD);

    assign o_cmd.load = accept;
    assign o_cmd.op   = t_cmd'(i_in_kind);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_EMPTY: begin
                if (accept) n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (accept)           n_state = ST_HOLD;
                else if (i_out_ready) n_state = ST_EMPTY;
            end
            default: n_state = ST_EMPTY;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: src/dmac4_dp.sv
// datapath: channel registers, port decode, transfer stepping and result register
`timescale 1ns / 1ps

module dmac4_dp
    import dmac4_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [7:0]  i_port,
    input  logic [7:0]  i_data,
    input  logic [1:0]  i_channel,
    output logic [7:0]  o_read_data,
    output logic [23:0] o_mem_addr,
    output logic        o_mem_read,
    output logic        o_mem_write,
    output logic [7:0]  o_mem_data
);

    logic        r_flip;
    logic [15:0] r_addr     [NUM_CH];
    logic [15:0] r_count    [NUM_CH];
    logic [15:0] r_rl_addr  [NUM_CH];
    logic [15:0] r_rl_count [NUM_CH];
    logic [7:0]  r_page     [NUM_CH];
    logic        r_auto     [NUM_CH];
    logic        r_dec      [NUM_CH];

    logic        n_flip;
    logic [15:0] n_addr     [NUM_CH];
    logic [15:0] n_count    [NUM_CH];
    logic [15:0] n_rl_addr  [NUM_CH];
    logic [15:0] n_rl_count [NUM_CH];
    logic [7:0]  n_page     [NUM_CH];
    logic        n_auto     [NUM_CH];
    logic        n_dec      [NUM_CH];

    logic [7:0]  r_read_data, n_read_data;
    logic [23:0] r_mem_addr,  n_mem_addr;
    logic        r_mem_read,  n_mem_read;
    logic        r_mem_write, n_mem_write;
    logic [7:0]  r_mem_data,  n_mem_data;

    logic [3:0]  nib;
    logic        is_page;
    logic [2:0]  pch_dec;
    logic [1:0]  pch;
    logic [1:0]  rch;
    logic [15:0] reg_val;
    logic [15:0] reg_new;
    logic [15:0] step_addr;
    logic [15:0] step_count;
    logic [1:0]  mode_ch;

    assign nib     = i_port[3:0];
    assign is_page = i_port[7];
    assign pch_dec = page_channel(nib);
    assign pch     = pch_dec[1:0];
    assign rch     = nib[2:1];
    assign mode_ch = i_data[1:0];

    // selected 16-bit register and its byte-merged write value
    assign reg_val = nib[0] ? r_count[rch] : r_addr[rch];
    assign reg_new = r_flip ? {i_data, reg_val[7:0]} : {reg_val[15:8], i_data};

    // transfer stepping on the item's channel
    assign step_addr  = r_dec[i_channel] ? (r_addr[i_channel] - 16'd1)
                                         : (r_addr[i_channel] + 16'd1);
    assign step_count = r_count[i_channel] - 16'd1;

    // item execution
    always_comb begin
        n_flip = r_flip;
        for (int c = 0; c < NUM_CH; c++) begin
            n_addr[c]     = r_addr[c];
            n_count[c]    = r_count[c];
            n_rl_addr[c]  = r_rl_addr[c];
            n_rl_count[c] = r_rl_count[c];
            n_page[c]     = r_page[c];
            n_auto[c]     = r_auto[c];
            n_dec[c]      = r_dec[c];
        end
        n_read_data = r_read_data;
        n_mem_addr  = r_mem_addr;
        n_mem_read  = r_mem_read;
        n_mem_write = r_mem_write;
        n_mem_data  = r_mem_data;

        if (i_cmd.load) begin
            n_read_data = 8'd0;
            n_mem_addr  = 24'd0;
            n_mem_read  = 1'b0;
            n_mem_write = 1'b0;
            n_mem_data  = 8'd0;
            unique case (i_cmd.op)
                CMD_PORT_RD: begin
                    if (is_page) begin
                        n_read_data = pch_dec[2] ? r_page[pch] : UNMAPPED_BYTE;
                    end else if (!nib[3]) begin
                        n_read_data = r_flip ? reg_val[15:8] : reg_val[7:0];
                        n_flip      = ~r_flip;
                    end else if (nib == NIB_STATUS) begin
                        n_read_data = STATUS_BYTE;
                    end else begin
                        n_read_data = UNMAPPED_BYTE;
                    end
                end
                CMD_PORT_WR: begin
                    if (is_page) begin
                        if (pch_dec[2]) n_page[pch] = i_data;
                    end else if (!nib[3]) begin
                        if (nib[0]) begin
                            n_count[rch]    = reg_new;
                            n_rl_count[rch] = reg_new;
                        end else begin
                            n_addr[rch]    = reg_new;
                            n_rl_addr[rch] = reg_new;
                        end
                        n_flip = ~r_flip;
                    end else begin
                        unique case (nib)
                            NIB_MODE: begin
                                n_auto[mode_ch] = i_data[MODE_AUTOINIT_BIT];
                                n_dec[mode_ch]  = i_data[MODE_DECREMENT_BIT];
                            end
                            NIB_CLR_FF: begin
                                n_flip = 1'b0;
                            end
                            NIB_MRESET: begin
                                n_flip = 1'b0;
                                for (int c = 0; c < NUM_CH; c++) begin
                                    n_addr[c]     = 16'd0;
                                    n_count[c]    = 16'd0;
                                    n_rl_addr[c]  = 16'd0;
                                    n_rl_count[c] = 16'd0;
                                    n_page[c]     = 8'd0;
                                    n_auto[c]     = 1'b0;
                                    n_dec[c]      = 1'b0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                CMD_XFER_RD, CMD_XFER_WR: begin
                    n_mem_addr = {r_page[i_channel], r_addr[i_channel]};
                    // count wraps to all ones: auto-init reloads both registers
                    if ((r_count[i_channel] == 16'd0) && r_auto[i_channel]) begin
                        n_addr[i_channel]  = r_rl_addr[i_channel];
                        n_count[i_channel] = r_rl_count[i_channel];
                    end else begin
                        n_addr[i_channel]  = step_addr;
                        n_count[i_channel] = step_count;
                    end
                    if (i_cmd.op == CMD_XFER_WR) begin
                        n_mem_write = 1'b1;
                        n_mem_data  = i_data;
                    end else begin
                        n_mem_read = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip <= 1'b0;
            for (int c = 0; c < NUM_CH; c++) begin
                r_addr[c]     <= 16'd0;
                r_count[c]    <= 16'd0;
                r_rl_addr[c]  <= 16'd0;
                r_rl_count[c] <= 16'd0;
                r_page[c]     <= 8'd0;
                r_auto[c]     <= 1'b0;
                r_dec[c]      <= 1'b0;
            end
        end else begin
            r_flip <= n_flip;
            for (int c = 0; c < NUM_CH; c++) begin
                r_addr[c]     <= n_addr[c];
                r_count[c]    <= n_count[c];
                r_rl_addr[c]  <= n_rl_addr[c];
                r_rl_count[c] <= n_rl_count[c];
                r_page[c]     <= n_page[c];
                r_auto[c]     <= n_auto[c];
                r_dec[c]      <= n_dec[c];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_read_data <= n_read_data;
        r_mem_addr  <= n_mem_addr;
        r_mem_read  <= n_mem_read;
        r_mem_write <= n_mem_write;
        r_mem_data  <= n_mem_data;
    end

    assign o_read_data = r_read_data;
    assign o_mem_addr  = r_mem_addr;
    assign o_mem_read  = r_mem_read;
    assign o_mem_write = r_mem_write;
    assign o_mem_data  = r_mem_data;

endmodule

FILE: src/dma_controller_four_channel_core.sv
// Four-channel DMA controller core, top level.
// Input stream: each item is a port read, a port write or a one-byte
// transfer. tuser carries the kind; tdata carries port, data and channel.
// Port items reach the per-channel 16-bit address and count registers
// through the shared byte flip-flop, plus page, mode, flip-flop clear,
// master reset and status. Transfer items return the 24-bit memory
// address and step that channel's address and count, with auto-init
// reload when the count wraps.
// Output stream: exactly one result item per input item, carrying
// read_data, mem_addr and mem_data in tdata and the read/write flags in tuser.
// The result is registered and presented in the cycle after the item is accepted.
// Throughput: one item per cycle while the receiver does not stall; all
// register updates finish in the accepting cycle, so the only limit is
// the single output register. Reset (synchronous, active low) clears
// all channel registers, the flip-flop and the output valid.
// When the receiver stalls, the result holds in the output register and
// s_axis_tready drops until it is taken; it rises again in the cycle the
// result leaves, so a new item can enter at the same edge.
`timescale 1ns / 1ps

module dma_controller_four_channel_core
    import dmac4_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // port[7:0], data[15:8], channel[17:16], zero fill
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // read_data[7:0], mem_addr[31:8], mem_data[39:32]
    output logic [1:0]  m_axis_tuser    // mem_read[0], mem_write[1]
);

    t_dp_cmd     cmd;
    logic [7:0]  read_data;
    logic [23:0] mem_addr;
    logic        mem_read;
    logic        mem_write;
    logic [7:0]  mem_data;

    // handshake control
    dmac4_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_kind   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    // channel registers and result
    dmac4_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_port      (s_axis_tdata[7:0]),
        .i_data      (s_axis_tdata[15:8]),
        .i_channel   (s_axis_tdata[17:16]),
        .o_read_data (read_data),
        .o_mem_addr  (mem_addr),
        .o_mem_read  (mem_read),
        .o_mem_write (mem_write),
        .o_mem_data  (mem_data)
    );

    // output packing
    assign m_axis_tdata = {mem_data, mem_addr, read_data};
    assign m_axis_tuser = {mem_write, mem_read};

endmodule
